### hdl/servo_ascii_command_framer_core_defines.svh
// Assertion macros for the servo command framer
`ifndef SERVO_ASCII_COMMAND_FRAMER_CORE_DEFINES_SVH
`define SERVO_ASCII_COMMAND_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SACF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacf check failed");

// next-cycle implication, checked outside reset
`define SACF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacf check failed");

`endif

### hdl/sacf_pkg.sv
// Types, control characters and helpers for the servo command framer
`timescale 1ns / 1ps

package sacf_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] action_t;
    typedef logic [4:0] len_t;

    localparam action_t ACT_READ    = 2'd0;
    localparam action_t ACT_WRITE4  = 2'd1;
    localparam action_t ACT_WRITE8  = 2'd2;
    localparam action_t ACT_INVALID = 2'd3;

    localparam char_t CH_EOT = 8'h04;
    localparam char_t CH_SOH = 8'h01;
    localparam char_t CH_STX = 8'h02;
    localparam char_t CH_ETX = 8'h03;

    localparam char_t DIGIT_BASE = 8'h30;
    localparam char_t ALPHA_BASE = 8'h41;

    localparam int FRAME_MAX = 19;
    localparam len_t LEN_READ   = 5'd11;
    localparam len_t LEN_WRITE4 = 5'd15;
    localparam len_t LEN_WRITE8 = 5'd19;

    // uppercase ASCII hex digit of one nibble
    function automatic char_t hex_digit(input logic [3:0] nib);
        char_t ext;
        ext = {4'h0, nib};
        if (nib < 4'd10)
            return DIGIT_BASE + ext;
        else
            return ALPHA_BASE + ext - 8'd10;
    endfunction

endpackage

### hdl/sacf_if.sv
// Valid/ready channels: command request in, frame word out
`timescale 1ns / 1ps

interface sacf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  command;
    logic [7:0]  data_no;
    logic [31:0] write_value;

    modport source (output valid, output action, output command, output data_no,
                    output write_value, input ready);
    modport sink (input valid, input action, input command, input data_no,
                  input write_value, output ready);
endinterface

interface sacf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

### hdl/servo_ascii_command_framer_core.sv
// Servo amplifier ASCII command framer: request in, serial frame words out
`timescale 1ns / 1ps
`include "servo_ascii_command_framer_core_defines.svh"

// Each accepted request becomes one command frame, sent one word per cycle on
// the frame channel while frame.ready is high: EOT, SOH, station digit, two
// command digits, STX, two data-number digits, 0/4/8 value digits, ETX, two
// checksum digits; last_byte marks the final checksum digit. Frames are 11,
// 15 or 19 words long (read, 4-digit write, 8-digit write), and the next frame
// loads as the final word of the current one is taken. A request passes three
// register stages (digit encode, partial sums, checksum and frame assembly)
// before the serializer, and up to three requests queue behind the frame being
// sent. Action code 3 is accepted and dropped. The station register should
// only be written while nothing is in flight.

module servo_ascii_command_framer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    sacf_cmd_if.sink           cmd,
    sacf_frame_if.source       frame
);

    localparam int FM = sacf_pkg::FRAME_MAX;

    logic [3:0] station_reg;

    // stage 1: digit encode
    logic                    s1_v_reg;
    sacf_pkg::action_t       s1_act_reg;
    sacf_pkg::char_t         s1_st_reg;
    sacf_pkg::char_t         s1_c_reg [2];
    sacf_pkg::char_t         s1_d_reg [2];
    sacf_pkg::char_t         s1_vd_reg [8];

    // stage 2: partial sums
    logic                    s2_v_reg;
    sacf_pkg::action_t       s2_act_reg;
    sacf_pkg::char_t         s2_st_reg;
    sacf_pkg::char_t         s2_c_reg [2];
    sacf_pkg::char_t         s2_d_reg [2];
    sacf_pkg::char_t         s2_vd_reg [8];
    sacf_pkg::char_t         s2_hsum_reg;
    sacf_pkg::char_t         s2_hi_reg;
    sacf_pkg::char_t         s2_lo_reg;

    // stage 3: assembled frame
    logic                    s3_v_reg;
    sacf_pkg::char_t         s3_frame_reg [FM];
    sacf_pkg::len_t          s3_len_reg;
    sacf_pkg::char_t         s3_frame_next [FM];
    sacf_pkg::len_t          s3_len_next;
    sacf_pkg::char_t         ck_sum;
    sacf_pkg::char_t         ck1;
    sacf_pkg::char_t         ck0;

    // serializer
    logic                    out_v_reg;
    sacf_pkg::len_t          rem_reg;
    sacf_pkg::char_t         shift_reg [FM];

    logic s1_adv, s2_adv, s3_adv, ser_free, ser_load, out_acc, in_acc;

    assign out_acc  = out_v_reg && frame.ready;
    assign ser_free = !out_v_reg || (frame.ready && (rem_reg == 5'd1));
    assign ser_load = s3_v_reg && ser_free;
    assign s3_adv   = !s3_v_reg || ser_load;
    assign s2_adv   = !s2_v_reg || s3_adv;
    assign s1_adv   = !s1_v_reg || s2_adv;
    assign in_acc   = cmd.valid && s1_adv;

    assign cmd.ready        = s1_adv;
    assign frame.valid      = out_v_reg;
    assign frame.frame_byte = shift_reg[0];
    assign frame.last_byte  = (rem_reg == 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            station_reg <= 4'h0;
        else if (cfg_we)
            station_reg <= cfg_wdata;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_v_reg <= cmd.valid && (cmd.action != sacf_pkg::ACT_INVALID);
            if (s2_adv)
                s2_v_reg <= s1_v_reg;
            if (s3_adv)
                s3_v_reg <= s2_v_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_act_reg <= cmd.action;
            s1_st_reg  <= sacf_pkg::hex_digit(station_reg);
            s1_c_reg[1] <= sacf_pkg::hex_digit(cmd.command[7:4]);
            s1_c_reg[0] <= sacf_pkg::hex_digit(cmd.command[3:0]);
            s1_d_reg[1] <= sacf_pkg::hex_digit(cmd.data_no[7:4]);
            s1_d_reg[0] <= sacf_pkg::hex_digit(cmd.data_no[3:0]);
            for (int i = 0; i < 8; i++)
                s1_vd_reg[i] <= sacf_pkg::hex_digit(cmd.write_value[i*4 +: 4]);
        end
    end

    // stage 2 payload: header sum and two value-digit sums, all mod 256
    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_v_reg)
        begin
            s2_act_reg <= s1_act_reg;
            s2_st_reg  <= s1_st_reg;
            s2_c_reg   <= s1_c_reg;
            s2_d_reg   <= s1_d_reg;
            s2_vd_reg  <= s1_vd_reg;
            s2_hsum_reg <= s1_st_reg + s1_c_reg[1] + s1_c_reg[0] + sacf_pkg::CH_STX
                         + s1_d_reg[1] + s1_d_reg[0] + sacf_pkg::CH_ETX;
            s2_hi_reg <= s1_vd_reg[7] + s1_vd_reg[6] + s1_vd_reg[5] + s1_vd_reg[4];
            s2_lo_reg <= s1_vd_reg[3] + s1_vd_reg[2] + s1_vd_reg[1] + s1_vd_reg[0];
        end
    end

    // stage 3: checksum and frame layout
    always_comb
    begin
        case (s2_act_reg)
            sacf_pkg::ACT_WRITE4: ck_sum = s2_hsum_reg + s2_lo_reg;
            sacf_pkg::ACT_WRITE8: ck_sum = s2_hsum_reg + s2_hi_reg + s2_lo_reg;
            default:              ck_sum = s2_hsum_reg;
        endcase
        ck1 = sacf_pkg::hex_digit(ck_sum[7:4]);
        ck0 = sacf_pkg::hex_digit(ck_sum[3:0]);

        for (int i = 0; i < FM; i++)
            s3_frame_next[i] = sacf_pkg::CH_ETX;
        s3_frame_next[0] = sacf_pkg::CH_EOT;
        s3_frame_next[1] = sacf_pkg::CH_SOH;
        s3_frame_next[2] = s2_st_reg;
        s3_frame_next[3] = s2_c_reg[1];
        s3_frame_next[4] = s2_c_reg[0];
        s3_frame_next[5] = sacf_pkg::CH_STX;
        s3_frame_next[6] = s2_d_reg[1];
        s3_frame_next[7] = s2_d_reg[0];

        case (s2_act_reg)
            sacf_pkg::ACT_WRITE4:
            begin
                for (int i = 0; i < 4; i++)
                    s3_frame_next[8 + i] = s2_vd_reg[3 - i];
                s3_frame_next[12] = sacf_pkg::CH_ETX;
                s3_frame_next[13] = ck1;
                s3_frame_next[14] = ck0;
                s3_len_next = sacf_pkg::LEN_WRITE4;
            end
            sacf_pkg::ACT_WRITE8:
            begin
                for (int i = 0; i < 8; i++)
                    s3_frame_next[8 + i] = s2_vd_reg[7 - i];
                s3_frame_next[16] = sacf_pkg::CH_ETX;
                s3_frame_next[17] = ck1;
                s3_frame_next[18] = ck0;
                s3_len_next = sacf_pkg::LEN_WRITE8;
            end
            default:
            begin
                s3_frame_next[8]  = sacf_pkg::CH_ETX;
                s3_frame_next[9]  = ck1;
                s3_frame_next[10] = ck0;
                s3_len_next = sacf_pkg::LEN_READ;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && s2_v_reg)
        begin
            s3_frame_reg <= s3_frame_next;
            s3_len_reg   <= s3_len_next;
        end
    end

    // serializer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else if (ser_load)
        begin
            out_v_reg <= 1'b1;
            rem_reg   <= s3_len_reg;
        end
        else if (out_acc)
        begin
            out_v_reg <= (rem_reg != 5'd1);
            rem_reg   <= rem_reg - 5'd1;
        end
    end

    // serializer shift line, word 0 is on the port
    always_ff @(posedge clk)
    begin
        if (ser_load)
            shift_reg <= s3_frame_reg;
        else if (out_acc)
        begin
            for (int i = 0; i < FM - 1; i++)
                shift_reg[i] <= shift_reg[i + 1];
        end
    end

    `SACF_ASSERT_NEXT(a_frame_starts_eot, ser_load, frame.frame_byte == sacf_pkg::CH_EOT)
    `SACF_ASSERT_NOW(a_rem_range, out_v_reg, (rem_reg != 5'd0) && (rem_reg <= sacf_pkg::LEN_WRITE8))
    `SACF_ASSERT_NEXT(a_drop_invalid, in_acc && (cmd.action == sacf_pkg::ACT_INVALID), !s1_v_reg)
    `SACF_ASSERT_NOW(a_load_when_free, ser_load, !out_v_reg || (out_acc && frame.last_byte))

endmodule
